[rtl/core/cssm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cssm_pkg;

  // Pattern storage: four 64-bit words, 32 bytes in all
  localparam int PAT_WORDS  = 4;
  localparam int PAT_BYTES  = 32;
  localparam int SHIFT_W    = 5;
  localparam int LEN_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int POS_OUT_W  = 16;

  typedef logic [7:0]            byte_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [CFG_DATA_W-1:0] word_t;

  // Register map
  localparam cfg_idx_t REG_PATTERN_0      = 3'd0;
  localparam cfg_idx_t REG_PATTERN_1      = 3'd1;
  localparam cfg_idx_t REG_PATTERN_2      = 3'd2;
  localparam cfg_idx_t REG_PATTERN_3      = 3'd3;
  localparam cfg_idx_t REG_PATTERN_LENGTH = 3'd4;

  // Case folding: bytes strictly between FOLD_LOW and FOLD_HIGH get FOLD_ADD
  localparam byte_t FOLD_LOW  = 8'h40;
  localparam byte_t FOLD_HIGH = 8'h5B;
  localparam byte_t FOLD_ADD  = 8'h20;

  function automatic byte_t fold_byte(input byte_t b);
    if (b > FOLD_LOW && b < FOLD_HIGH) begin
      return b + FOLD_ADD;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/core/cssm_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One window cell: holds a text byte and its valid flag, hands both to the
// next cell on every shift, and compares its byte with its pattern byte.
module cssm_cell
  import cssm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  shift,
  input  wire byte_t byte_in,
  input  wire logic  valid_in,
  input  wire byte_t pat_byte,
  input  wire logic  in_use,
  output byte_t      byte_out,
  output logic       valid_out,
  output logic       hit
);

  byte_t data;
  logic  valid;

  // Window storage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= valid_in;
    end
    if (shift) begin
      data <= byte_in;
    end
  end

  // Unused cells always agree
  assign hit       = !in_use || (valid && (data == pat_byte));
  assign byte_out  = data;
  assign valid_out = valid;

endmodule

`default_nettype wire

[rtl/core/cssm_align.sv]
`timescale 1ns / 1ps
`default_nettype none

// Lines the pattern up with the window: cell i (newest byte at cell 0) must
// equal pattern byte len-1-i. Reverse the pattern, then shift right by
// 32-len bytes through a log shifter.
module cssm_align
  import cssm_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  wire word_t pat_words [PAT_WORDS],
  input  wire len_t  pat_len,
  output byte_t      cell_pat  [PATTERN_MAX],
  output logic       cell_use  [PATTERN_MAX],
  output logic       len_ok
);

  logic [8*PAT_BYTES-1:0] flat;
  logic [8*PAT_BYTES-1:0] rev;
  logic [8*PAT_BYTES-1:0] shifted;
  logic [SHIFT_W-1:0]     sh;

  assign flat = {pat_words[3], pat_words[2], pat_words[1], pat_words[0]};
  assign sh   = SHIFT_W'(LEN_W'(PAT_BYTES) - pat_len);

  // Byte reversal and shift
  always_comb begin
    for (int k = 0; k < PAT_BYTES; k++) begin
      rev[8*k +: 8] = flat[8*(PAT_BYTES-1-k) +: 8];
    end
    shifted = rev;
    for (int s = 0; s < SHIFT_W; s++) begin
      if (sh[s]) begin
        shifted = shifted >> (8 << s);
      end
    end
  end

  // Per-cell pattern byte and in-use flag
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      cell_pat[i] = shifted[8*i +: 8];
      cell_use[i] = LEN_W'(i) < pat_len;
    end
  end

  assign len_ok = (pat_len != '0) && (pat_len <= LEN_W'(PATTERN_MAX));

endmodule

`default_nettype wire

[rtl/core/caseless_substring_match.sv]
`timescale 1ns / 1ps
`default_nettype none

// Caseless substring search over a byte stream.
// Text channel: text_valid/text_stall carry text_byte and last_byte, one
// item per cycle while text_stall is low. Uppercase ASCII is folded to
// lowercase and the byte enters a row of PATTERN_MAX window cells; all
// cells compare against the pattern in the cycle after the byte is taken.
// Result channel: result_valid/result_stall carry found, match_position and
// ends_at_end. One result per text: the item with last_byte is registered
// in stage one and then loaded into the output register. Throughput is one
// text byte per cycle while text_stall is low; the window compare is
// combinational and the cell row shifts every accepted byte.
// Config: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Index 0..3 write pattern words, 4 writes the length; other
// indexes are ignored.
// Reset clears the pattern, the length and the per-text state, and empties
// the output register. When the receiver stalls, the result holds; the block
// keeps taking text until a second final byte is waiting for the output
// register, then raises text_stall until the result is taken.
module caseless_substring_match
  import cssm_pkg::*;
#(
  parameter int PATTERN_MAX = 32,
  parameter int TEXT_MAX    = 65536
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 text_valid,
  output logic                      text_stall,
  input  wire logic [7:0]           text_byte,
  input  wire logic                 last_byte,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic                      found,
  output logic [POS_OUT_W-1:0]      match_position,
  output logic                      ends_at_end,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int POS_W = $clog2(TEXT_MAX + 1);

  // Configuration registers
  word_t pat_words [PAT_WORDS];
  len_t  pat_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < PAT_WORDS; w++) begin
        pat_words[w] <= '0;
      end
      pat_len <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index) inside
        REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3: begin
          pat_words[cfg_index[1:0]] <= cfg_data;
        end
        REG_PATTERN_LENGTH: begin
          pat_len <= cfg_data[LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake and pipeline control
  logic             in_acc;
  logic             out_blocked;
  logic             b_fire;
  logic             s1_valid;
  logic             s1_last;
  logic             s1_pos_ok;
  logic [POS_W-1:0] s1_pos;
  logic [POS_W-1:0] pos;
  logic             text_start;

  assign out_blocked = result_valid && result_stall;
  assign text_stall  = s1_valid && s1_last && out_blocked;
  assign in_acc      = text_valid && !text_stall;
  assign b_fire      = s1_valid && !(s1_last && out_blocked);

  // Stage one: position tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      pos        <= '0;
      text_start <= 1'b1;
    end else begin
      if (in_acc) begin
        s1_valid   <= 1'b1;
        text_start <= last_byte;
        if (last_byte) begin
          pos <= '0;
        end else if (pos < POS_W'(TEXT_MAX)) begin
          pos <= pos + POS_W'(1);
        end
      end else if (b_fire) begin
        s1_valid <= 1'b0;
      end
    end
    if (in_acc) begin
      s1_last   <= last_byte;
      s1_pos    <= pos;
      s1_pos_ok <= pos < POS_W'(TEXT_MAX);
    end
  end

  // Pattern alignment
  byte_t cell_pat [PATTERN_MAX];
  logic  cell_use [PATTERN_MAX];
  logic  len_ok;

  cssm_align #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_align (
    .pat_words (pat_words),
    .pat_len   (pat_len),
    .cell_pat  (cell_pat),
    .cell_use  (cell_use),
    .len_ok    (len_ok)
  );

  // Window cell row, newest byte in cell 0
  byte_t                  win_byte [PATTERN_MAX];
  logic                   win_valid [PATTERN_MAX];
  byte_t                  chain_byte [PATTERN_MAX];
  logic                   chain_valid [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] hits;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign chain_byte[i]  = fold_byte(text_byte);
      assign chain_valid[i] = 1'b1;
    end else begin : g_tail
      assign chain_byte[i]  = win_byte[i-1];
      assign chain_valid[i] = win_valid[i-1] && !text_start;
    end

    cssm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (in_acc),
      .byte_in   (chain_byte[i]),
      .valid_in  (chain_valid[i]),
      .pat_byte  (cell_pat[i]),
      .in_use    (cell_use[i]),
      .byte_out  (win_byte[i]),
      .valid_out (win_valid[i]),
      .hit       (hits[i])
    );
  end

  // Stage two: match bookkeeping and result
  logic                 window_match;
  logic                 record;
  logic                 match_seen;
  logic                 first_at_end;
  logic [POS_OUT_W-1:0] first_start;
  logic [POS_OUT_W-1:0] start_next;

  assign window_match = len_ok && (&hits);
  assign record       = !match_seen && s1_pos_ok && window_match;
  assign start_next   = POS_OUT_W'(s1_pos) + POS_OUT_W'(1) - POS_OUT_W'(pat_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      match_seen   <= 1'b0;
      first_at_end <= 1'b0;
      first_start  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (b_fire && s1_last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (b_fire) begin
        if (s1_last) begin
          match_seen   <= 1'b0;
          first_at_end <= 1'b0;
          first_start  <= '0;
        end else if (record) begin
          match_seen   <= 1'b1;
          first_at_end <= 1'b0;
          first_start  <= start_next;
        end
      end
    end
    if (b_fire && s1_last) begin
      found          <= match_seen || record;
      match_position <= match_seen ? first_start : (record ? start_next : '0);
      ends_at_end    <= match_seen ? first_at_end : record;
    end
  end

endmodule

`default_nettype wire

[rtl/core/cssm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks for the substring search block
module cssm_checker
  import cssm_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 text_stall,
  input wire logic                 result_valid,
  input wire logic                 result_stall,
  input wire logic                 found,
  input wire logic [POS_OUT_W-1:0] match_position,
  input wire logic                 ends_at_end
);

  // A stalled result stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(found)
      && $stable(match_position) && $stable(ends_at_end))
    else $error("stalled result changed");

  // A miss carries no position and no end flag
  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> match_position == '0 && !ends_at_end)
    else $error("miss result has nonzero fields");

  // Text is held back only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> result_valid && result_stall)
    else $error("text stalled without a blocked result");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind caseless_substring_match cssm_checker u_cssm_checker (
  .clk            (clk),
  .rst            (rst),
  .text_stall     (text_stall),
  .result_valid   (result_valid),
  .result_stall   (result_stall),
  .found          (found),
  .match_position (match_position),
  .ends_at_end    (ends_at_end)
);

`default_nettype wire

[tb/caseless_substring_match_tb.sv]
`timescale 1ns / 1ps

module caseless_substring_match_tb
  import cssm_pkg::*;
();

  localparam int TEXT_LIMIT = 65536;
  localparam byte_t LOWER_A = 8'h61;
  localparam byte_t LOWER_Z = 8'h7A;
  localparam byte_t UPPER_A = 8'h41;

  typedef byte_t byte_q_t[$];

  typedef struct packed {
    logic                 found;
    logic [POS_OUT_W-1:0] position;
    logic                 at_end;
  } match_report_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_style_t;

  // Tracks the pattern registers and per-text search state, queues the
  // report each finished text should produce and compares actual reports.
  class match_scoreboard;
    word_t         pattern_word[PAT_WORDS];
    len_t          pattern_len;
    byte_t         window[PAT_BYTES];
    int unsigned   text_offset;
    int unsigned   window_fill;
    bit            match_seen;
    logic [15:0]   first_start;
    bit            first_at_end;
    match_report_t expected_reports[$];
    int unsigned   failures;

    function new();
      foreach (pattern_word[i]) pattern_word[i] = '0;
      pattern_len = '0;
      failures = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (window[i]) window[i] = '0;
      text_offset = 0;
      window_fill = 0;
      match_seen = 1'b0;
      first_start = '0;
      first_at_end = 1'b0;
    endfunction

    function void write_reg(cfg_idx_t idx, word_t data);
      case (idx)
        REG_PATTERN_0: pattern_word[0] = data;
        REG_PATTERN_1: pattern_word[1] = data;
        REG_PATTERN_2: pattern_word[2] = data;
        REG_PATTERN_3: pattern_word[3] = data;
        REG_PATTERN_LENGTH: pattern_len = data[LEN_W-1:0];
        default: ;  // unmapped index: dropped
      endcase
    endfunction

    // Newest byte sits in window[0], so pattern byte j lines up with
    // window[len-1-j].
    function bit window_hit();
      int unsigned len;
      byte_t pb;
      len = pattern_len;
      if (len == 0 || len > PAT_BYTES || window_fill < len) return 1'b0;
      for (int j = 0; j < len; j++) begin
        pb = pattern_word[j / 8][(j % 8) * 8 +: 8];
        if (window[len - 1 - j] != pb) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_text_byte(byte_t b, bit last);
      byte_t folded;
      int unsigned start;
      match_report_t r;
      folded = (b > FOLD_LOW && b < FOLD_HIGH) ? byte_t'(b + FOLD_ADD) : b;
      for (int k = PAT_BYTES - 1; k > 0; k--) window[k] = window[k - 1];
      window[0] = folded;
      if (window_fill < PAT_BYTES) window_fill++;
      // only the first match counts, and only below the position limit
      if (!match_seen && text_offset < TEXT_LIMIT && window_hit()) begin
        match_seen = 1'b1;
        start = text_offset + 1 - pattern_len;
        first_start = start[15:0];
        first_at_end = last;
      end
      if (text_offset < TEXT_LIMIT) text_offset++;
      if (last) begin
        r.found = match_seen;
        r.position = match_seen ? first_start : '0;
        r.at_end = match_seen && first_at_end;
        expected_reports.push_back(r);
        clear_text();
      end
    endfunction

    function void check_result(logic f, logic [POS_OUT_W-1:0] p, logic e);
      match_report_t want;
      match_report_t got;
      got = '{found: f, position: p, at_end: e};
      if (expected_reports.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: found=%0b match_position=%0d ends_at_end=%0b",
                   f, p, e);
        return;
      end
      want = expected_reports.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected found=%0b match_position=%0d ends_at_end=%0b,",
                   want.found, want.position, want.at_end,
                   " got found=%0b match_position=%0d ends_at_end=%0b", f, p, e);
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  text_valid = 1'b0;
  logic                  text_stall;
  logic [7:0]            text_byte = '0;
  logic                  last_byte = 1'b0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic                  found;
  logic [POS_OUT_W-1:0]  match_position;
  logic                  ends_at_end;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  match_scoreboard sb = new();

  cfg_idx_t pattern_regs[PAT_WORDS] = '{REG_PATTERN_0, REG_PATTERN_1,
                                         REG_PATTERN_2, REG_PATTERN_3};
  byte_q_t  cur_pattern;
  byte_q_t  text_buf;
  int       burst_left = 0;
  bit       sender_idles = 1'b1;
  stall_style_t stall_style = STALL_NONE;
  int       stall_left = 0;

  caseless_substring_match DUT (
    .clk            (clk),
    .rst            (rst),
    .text_valid     (text_valid),
    .text_stall     (text_stall),
    .text_byte      (text_byte),
    .last_byte      (last_byte),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .found          (found),
    .match_position (match_position),
    .ends_at_end    (ends_at_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: switches at random among three stall styles, none, light and heavy
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 2));
      stall_left = $urandom_range(20, 200);
    end
    stall_left = stall_left - 1;
    case (stall_style)
      STALL_NONE: result_stall <= 1'b0;
      STALL_LIGHT: result_stall <= ($urandom_range(0, 1) == 1);
      default: result_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result(found, match_position, ends_at_end);
  end

  // Run limit
  initial begin
    #10000000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic write_reg(input cfg_idx_t idx, input word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  function automatic word_t length_word(input int len);
    word_t w;
    w = {$urandom, $urandom};
    w[LEN_W-1:0] = len[LEN_W-1:0];
    return w;
  endfunction

  // Writes all four pattern words (random fill past the pattern) and the
  // length, optionally followed by writes to unmapped indexes.
  task automatic load_pattern(input byte_q_t pat, input word_t len_data, input bit junk);
    word_t w;
    cfg_idx_t idx;
    cur_pattern = pat;
    for (int i = 0; i < PAT_WORDS; i++) begin
      w = {$urandom, $urandom};
      for (int k = 0; k < 8; k++)
        if (i * 8 + k < pat.size()) w[k * 8 +: 8] = pat[i * 8 + k];
      write_reg(pattern_regs[i], w);
    end
    write_reg(REG_PATTERN_LENGTH, len_data);
    if (junk) begin
      repeat ($urandom_range(1, 3)) begin
        idx = cfg_idx_t'($urandom_range(REG_PATTERN_LENGTH + 1, (1 << CFG_IDX_W) - 1));
        write_reg(idx, {$urandom, $urandom});
      end
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Sender: bursts of random length, with random gaps in between when sender_idles is set
  task automatic send_text_byte(input byte_t b, input bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_idles ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
        text_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    text_valid <= 1'b1;
    text_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    sb.note_text_byte(b, last);
  endtask

  task automatic send_text_buf();
    foreach (text_buf[i]) send_text_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  // Pause the sender until every report is in, then let the window
  // compare of the final byte settle before any register write.
  task automatic wait_for_results();
    text_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic byte_t random_case(input byte_t b);
    if (b >= LOWER_A && b <= LOWER_Z && $urandom_range(0, 1) == 1) return b - FOLD_ADD;
    return b;
  endfunction

  function automatic byte_t text_filler();
    if (cur_pattern.size() != 0 && $urandom_range(0, 1) == 1)
      return random_case(cur_pattern[$urandom_range(0, cur_pattern.size() - 1)]);
    return random_case(byte_t'(LOWER_A + $urandom_range(0, 3)));
  endfunction

  function automatic byte_q_t random_pattern(input int len);
    byte_q_t pat;
    int r;
    for (int i = 0; i < len && i < PAT_BYTES; i++) begin
      r = $urandom_range(0, 19);
      if (r < 12) pat.push_back(byte_t'(LOWER_A + $urandom_range(0, 3)));
      else if (r < 15) pat.push_back(byte_t'($urandom));
      else if (r == 15) pat.push_back(byte_t'(UPPER_A + $urandom_range(0, 3)));
      else if (r == 16) pat.push_back(8'h00);
      else pat.push_back(byte_t'(LOWER_A + $urandom_range(0, 25)));
    end
    return pat;
  endfunction

  function automatic int random_length();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return PAT_BYTES;
      2: return $urandom_range(PAT_BYTES + 1, (1 << LEN_W) - 1);
      3: return 1;
      4: return PAT_BYTES - 1;
      default: return $urandom_range(2, 8);
    endcase
  endfunction

  // Mostly filler with the pattern planted (case scrambled), sometimes
  // truncated or planted twice; the rest is raw noise.
  task automatic make_text();
    int n;
    int at;
    int keep;
    text_buf.delete();
    n = $urandom_range(0, 30);
    if ($urandom_range(0, 9) == 0) begin
      repeat (n + 1) text_buf.push_back(byte_t'($urandom));
      return;
    end
    repeat (n) text_buf.push_back(text_filler());
    if (cur_pattern.size() != 0 && $urandom_range(0, 9) < 7) begin
      keep = cur_pattern.size();
      if ($urandom_range(0, 5) == 0) keep = $urandom_range(0, keep - 1);
      at = ($urandom_range(0, 3) == 0) ? text_buf.size() : $urandom_range(0, text_buf.size());
      for (int j = keep - 1; j >= 0; j--) text_buf.insert(at, random_case(cur_pattern[j]));
      if ($urandom_range(0, 3) == 0)
        foreach (cur_pattern[j]) text_buf.push_back(random_case(cur_pattern[j]));
    end
    if (text_buf.size() == 0) text_buf.push_back(text_filler());
  endtask

  task automatic run_phase(input byte_q_t pat, input int len, input int budget);
    int sent;
    load_pattern(pat, length_word(len), $urandom_range(0, 3) == 0);
    sender_idles = ($urandom_range(0, 4) != 0);
    sent = 0;
    while (sent < budget) begin
      make_text();
      send_text_buf();
      sent += text_buf.size();
    end
    wait_for_results();
  endtask

  initial begin
    byte_q_t pat;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: pattern "abc"
    load_pattern('{8'h61, 8'h62, 8'h63}, length_word(3), 1'b1);
    text_buf = '{8'h78, 8'h41, 8'h42, 8'h63};  // folded match ending on last byte
    send_text_buf();
    text_buf = '{8'h00, 8'hFF, 8'h40, 8'h5B, 8'h41, 8'h5A};  // fold edges
    send_text_buf();
    text_buf = '{8'h61};  // single-byte text
    send_text_buf();
    text_buf = '{8'h61, 8'h62, 8'h63, 8'h7A, 8'h61, 8'h62, 8'h63};  // first of two
    send_text_buf();
    wait_for_results();

    // zero length never matches
    load_pattern('{8'h61, 8'h62, 8'h63}, length_word(0), 1'b0);
    text_buf = '{8'h61, 8'h62, 8'h63};
    send_text_buf();
    wait_for_results();

    // uppercase pattern cannot match folded text
    load_pattern('{8'h41, 8'h42, 8'h43}, length_word(3), 1'b1);
    text_buf = '{8'h41, 8'h42, 8'h43};
    send_text_buf();
    wait_for_results();

    // Random settings
    for (int p = 0; p < 16; p++) begin
      int len;
      len = random_length();
      run_phase(random_pattern(len), len, 80);
    end

    // Extreme pattern words and lengths
    pat.delete();
    repeat (PAT_BYTES) pat.push_back(8'h00);
    run_phase(pat, PAT_BYTES, 80);
    pat.delete();
    repeat (PAT_BYTES) pat.push_back(8'hFF);
    run_phase(pat, PAT_BYTES, 80);
    run_phase(random_pattern(PAT_BYTES), (1 << LEN_W) - 1, 40);
    run_phase(random_pattern(4), 0, 40);

    repeat (16) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
